@@ rtl/lpg_pkg.sv @@
// ---------------------------------------------------------------------------
// Line pixel generator package
// Shared widths, register indexes, mode codes and the sequencer state type.
// ---------------------------------------------------------------------------
package lpg_pkg;

   localparam int COORD_BITS_DEFAULT   = 13;
   localparam int ADDRESS_BITS_DEFAULT = 25;
   localparam int DIM_BITS             = 12;
   localparam int COLOR_BITS           = 24;
   localparam int CSR_INDEX_BITS       = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET  = DIM_BITS'(1920);
   localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET = DIM_BITS'(1080);

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_MINOR,
      ST_ADDR_MUL,
      ST_LIM_MUL,
      ST_ADDR
   } lpg_state_type;

endpackage

@@ rtl/lpg_if.sv @@
// ---------------------------------------------------------------------------
// Line pixel generator channels
// Request, response and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface lpg_req_if
   import lpg_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEFAULT)
   ();
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] finish_x;
   logic signed [COORD_BITS-1:0] finish_y;
   logic [COLOR_BITS-1:0]        line_color;

   modport source (output valid, mode, start_x, start_y, finish_x, finish_y, line_color,
                   input ready);
   modport sink (input valid, mode, start_x, start_y, finish_x, finish_y, line_color,
                 output ready);
endinterface

interface lpg_rsp_if
   import lpg_pkg::*;
   #(parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT)
   ();
   logic                           valid;
   logic                           ready;
   logic signed [ADDRESS_BITS-1:0] pixel_address;
   logic                           address_ok;
   logic [COLOR_BITS-1:0]          pixel_color;
   logic                           last_pixel;

   modport source (output valid, pixel_address, address_ok, pixel_color, last_pixel,
                   input ready);
   modport sink (input valid, pixel_address, address_ok, pixel_color, last_pixel,
                 output ready);
endinterface

interface lpg_csr_if
   import lpg_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DIM_BITS-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/line_pixel_generator_top.sv @@
// ---------------------------------------------------------------------------
// Line pixel generator
// Slope-intercept line rasterizer producing linear frame-buffer pixel words.
// ---------------------------------------------------------------------------
// A start word runs through the multiply, divider load, divide and minor states
// to form the intercept; a zero-length line finishes in its accept cycle.
// A step word runs through the same states, then address multiply, limit multiply
// and address, which waits while the output stalls, before its pixel is registered.
// One word is worked on at a time. A step with no active line returns at once.
// Synchronous reset clears the line state and sets width 1920, height 1080.
module line_pixel_generator_top
   import lpg_pkg::*;
   #(
   parameter int COORD_BITS   = COORD_BITS_DEFAULT,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
   )
   (
   input logic    clock,
   input logic    reset,
   lpg_req_if.sink   req_port,
   lpg_rsp_if.source rsp_port,
   lpg_csr_if.sink   csr_port
   );

   localparam int DELTA_W  = COORD_BITS + 1;
   localparam int MINOR_W  = COORD_BITS + 2;
   localparam int MUL_W    = (MINOR_W > DIM_BITS + 1) ? MINOR_W : DIM_BITS + 1;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ADDR_W   = PROD_W + 1;
   localparam int OUT_EXT  = (ADDRESS_BITS > ADDR_W) ? ADDRESS_BITS : ADDR_W;

   lpg_state_type state_ff, state_in;

   logic [DIM_BITS-1:0]          width_ff;
   logic [DIM_BITS-1:0]          height_ff;
   logic                         line_active_ff;
   logic                         major_is_x_ff;
   logic signed [COORD_BITS-1:0] major_index_ff;
   logic signed [COORD_BITS-1:0] major_end_ff;
   logic signed [DELTA_W-1:0]    delta_minor_ff;
   logic signed [DELTA_W-1:0]    delta_major_ff;
   logic signed [MINOR_W-1:0]    intercept_ff;
   logic [COLOR_BITS-1:0]        held_color_ff;
   logic                         op_start_ff;
   logic                         neg_ff;
   logic signed [MINOR_W-1:0]    minor_ff;
   logic signed [ADDR_W-1:0]     addr_ff;

   logic                           rsp_valid_ff;
   logic signed [ADDRESS_BITS-1:0] rsp_address_ff;
   logic                           rsp_ok_ff;
   logic [COLOR_BITS-1:0]          rsp_color_ff;
   logic                           rsp_last_ff;

   // Start word decode.
   logic signed [DELTA_W-1:0]    dx, dy;
   logic [DELTA_W-1:0]           abs_dx, abs_dy;
   logic                         start_major_x;
   logic signed [COORD_BITS-1:0] sel_ma1, sel_ma2, sel_mi1, sel_mi2;
   logic signed [COORD_BITS-1:0] ma1, ma2, mi1, mi2;
   logic signed [DELTA_W-1:0]    start_dmajor, start_dminor;

   logic req_fire, step_ok, out_free, div_start, div_done;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0]   product;
   logic signed [PROD_W-1:0]   prod_mag;
   logic [COORD_BITS-1:0]      quotient;
   logic signed [MINOR_W-1:0]  q_signed;
   logic signed [MINOR_W-1:0]  pix_x, pix_y;
   logic signed [OUT_EXT-1:0]  addr_ext;
   logic                       addr_ok;
   logic                       last;
   logic signed [COORD_BITS:0] index_next;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      dx = DELTA_W'(req_port.finish_x) - DELTA_W'(req_port.start_x);
      dy = DELTA_W'(req_port.finish_y) - DELTA_W'(req_port.start_y);
      abs_dx = dx[DELTA_W-1] ? -dx : dx;
      abs_dy = dy[DELTA_W-1] ? -dy : dy;
      start_major_x = abs_dx > abs_dy;
      if (start_major_x) begin
         sel_ma1 = req_port.start_x;
         sel_ma2 = req_port.finish_x;
         sel_mi1 = req_port.start_y;
         sel_mi2 = req_port.finish_y;
      end else begin
         sel_ma1 = req_port.start_y;
         sel_ma2 = req_port.finish_y;
         sel_mi1 = req_port.start_x;
         sel_mi2 = req_port.finish_x;
      end
      if (sel_ma2 < sel_ma1) begin
         ma1 = sel_ma2;
         ma2 = sel_ma1;
         mi1 = sel_mi2;
         mi2 = sel_mi1;
      end else begin
         ma1 = sel_ma1;
         ma2 = sel_ma2;
         mi1 = sel_mi1;
         mi2 = sel_mi2;
      end
      start_dmajor = DELTA_W'(ma2) - DELTA_W'(ma1);
      start_dminor = DELTA_W'(mi2) - DELTA_W'(mi1);
   end

   assign step_ok = line_active_ff && (major_index_ff < major_end_ff);

   // Datapath arithmetic around the shared units.
   assign prod_mag = product[PROD_W-1] ? -product : product;
   assign q_signed = neg_ff ? -MINOR_W'(signed'({1'b0, quotient}))
                            :  MINOR_W'(signed'({1'b0, quotient}));
   assign pix_x    = major_is_x_ff ? MINOR_W'(major_index_ff) : minor_ff;
   assign pix_y    = major_is_x_ff ? minor_ff : MINOR_W'(major_index_ff);
   assign addr_ext = OUT_EXT'(addr_ff);
   assign addr_ok  = !addr_ff[ADDR_W-1] && (addr_ff < ADDR_W'(product));
   assign index_next = (COORD_BITS + 1)'(major_index_ff) + (COORD_BITS + 1)'(1);
   assign last     = index_next >= (COORD_BITS + 1)'(major_end_ff);

   lpg_mul #(.OP_BITS(MUL_W)) u_mul (
      .clock      (clock),
      .operand_a  (mul_a),
      .operand_b  (mul_b),
      .product_ff (product)
   );

   lpg_div #(.COORD_BITS(COORD_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag[2*COORD_BITS-1:0]),
      .divisor  (delta_major_ff[COORD_BITS-1:0]),
      .quotient (quotient),
      .done_ff  (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      mul_a     = MUL_W'(major_index_ff);
      mul_b     = MUL_W'(delta_minor_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_port.mode == MODE_START) begin
                  if (start_dmajor != '0) state_in = ST_MUL;
               end else if (step_ok) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_MINOR;
         end
         ST_MINOR: begin
            state_in = op_start_ff ? ST_IDLE : ST_ADDR_MUL;
         end
         ST_ADDR_MUL: begin
            mul_a    = MUL_W'(pix_y);
            mul_b    = MUL_W'(signed'({1'b0, width_ff}));
            state_in = ST_LIM_MUL;
         end
         ST_LIM_MUL: begin
            mul_a    = MUL_W'(signed'({1'b0, width_ff}));
            mul_b    = MUL_W'(signed'({1'b0, height_ff}));
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            // Keep the frame size product in place while the output is stalled.
            mul_a = MUL_W'(signed'({1'b0, width_ff}));
            mul_b = MUL_W'(signed'({1'b0, height_ff}));
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register writes are taken at any time; software is to write only while idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_port.valid && csr_port.ready) begin
         if (csr_port.index == REG_IMAGE_WIDTH) width_ff <= csr_port.data;
         if (csr_port.index == REG_IMAGE_HEIGHT) height_ff <= csr_port.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         major_is_x_ff  <= 1'b0;
         major_index_ff <= '0;
         major_end_ff   <= '0;
         delta_minor_ff <= '0;
         delta_major_ff <= '0;
         intercept_ff   <= '0;
         held_color_ff  <= '0;
         op_start_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            if (req_port.mode == MODE_START) begin
               major_is_x_ff  <= start_major_x;
               major_index_ff <= ma1;
               major_end_ff   <= ma2;
               delta_major_ff <= start_dmajor;
               delta_minor_ff <= start_dminor;
               held_color_ff  <= req_port.line_color;
               line_active_ff <= 1'b0;
               op_start_ff    <= 1'b1;
               // The intercept register holds the first minor coordinate until
               // the division result is subtracted from it.
               intercept_ff   <= (start_dmajor == '0) ? '0 : MINOR_W'(mi1);
            end else begin
               op_start_ff <= 1'b0;
               if (!step_ok) line_active_ff <= 1'b0;
            end
         end
         if (state_ff == ST_MINOR && op_start_ff) begin
            intercept_ff   <= intercept_ff - q_signed;
            line_active_ff <= 1'b1;
         end
         if (state_ff == ST_ADDR && out_free) begin
            major_index_ff <= index_next[COORD_BITS-1:0];
            if (last) line_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV_LOAD) neg_ff <= product[PROD_W-1];
      if (state_ff == ST_MINOR) minor_ff <= q_signed + intercept_ff;
      if (state_ff == ST_LIM_MUL) addr_ff <= ADDR_W'(pix_x) + ADDR_W'(product);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_ADDR && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR && out_free) begin
         rsp_address_ff <= addr_ext[ADDRESS_BITS-1:0];
         rsp_ok_ff      <= addr_ok;
         rsp_color_ff   <= held_color_ff;
         rsp_last_ff    <= last;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.pixel_address = rsp_address_ff;
   assign rsp_port.address_ok    = rsp_ok_ff;
   assign rsp_port.pixel_color   = rsp_color_ff;
   assign rsp_port.last_pixel    = rsp_last_ff;

   // The divider reports completion only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   // An active line always has pixels left to draw.
   assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> major_index_ff < major_end_ff)
      else $error("active line has run past its end point");

   // Every arithmetic pass divides by a nonzero major delta.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_LOAD |-> delta_major_ff > '0)
      else $error("division started with a zero major delta");

   // A finished pixel always lands in the output register on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR && out_free) |=> rsp_valid_ff)
      else $error("finished pixel did not reach the output register");

endmodule

@@ rtl/lpg_mul.sv @@
// ---------------------------------------------------------------------------
// Line pixel generator shared multiplier
// Signed multiplier with a registered product, time-shared by the sequencer.
// ---------------------------------------------------------------------------
module lpg_mul
   import lpg_pkg::*;
   #(parameter int OP_BITS = COORD_BITS_DEFAULT + 2)
   (
   input  logic                          clock,
   input  logic signed [OP_BITS-1:0]     operand_a,
   input  logic signed [OP_BITS-1:0]     operand_b,
   output logic signed [2*OP_BITS-1:0]   product_ff
   );

   always_ff @(posedge clock) begin
      product_ff <= operand_a * operand_b;
   end

endmodule

@@ rtl/lpg_div.sv @@
// ---------------------------------------------------------------------------
// Line pixel generator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lpg_div
   import lpg_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEFAULT)
   (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2*COORD_BITS-1:0]   dividend,
   input  logic [COORD_BITS-1:0]     divisor,
   output logic [COORD_BITS-1:0]     quotient,
   output logic                      done_ff
   );

   localparam int CNT_W = $clog2(COORD_BITS + 1);

   logic [COORD_BITS-1:0] rem_ff;
   logic [COORD_BITS-1:0] quo_ff;
   logic [COORD_BITS-1:0] div_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  running_ff;
   logic [COORD_BITS:0]   shifted;
   logic [COORD_BITS+1:0] diff;

   // The quotient always fits in COORD_BITS, so the upper half of the dividend
   // is already below the divisor and only COORD_BITS steps are needed.
   assign shifted = {rem_ff, quo_ff[COORD_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            running_ff <= 1'b1;
            count_ff   <= CNT_W'(COORD_BITS);
         end else if (running_ff) begin
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[2*COORD_BITS-1:COORD_BITS];
         quo_ff <= dividend[COORD_BITS-1:0];
         div_ff <= divisor;
      end else if (running_ff) begin
         if (!diff[COORD_BITS+1]) begin
            rem_ff <= diff[COORD_BITS-1:0];
            quo_ff <= {quo_ff[COORD_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[COORD_BITS-1:0];
            quo_ff <= {quo_ff[COORD_BITS-2:0], 1'b0};
         end
      end
   end

endmodule

@@ dv/line_pixel_generator_top_test.sv @@
// ---------------------------------------------------------------------------
// Line pixel generator testbench
// Drives start and step words with random gaps on both channels, predicts
// each pixel word from a slope-intercept model kept in a scoreboard class,
// and checks every returned pixel field by field, over several image sizes.
// ---------------------------------------------------------------------------
module line_pixel_generator_top_test
   import lpg_pkg::*;
   ;

   localparam int CB            = COORD_BITS_DEFAULT;
   localparam int AB            = ADDRESS_BITS_DEFAULT;
   localparam int SETTLE_CYCLES = 2 * (COORD_BITS_DEFAULT + 8);
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 88;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = REG_IMAGE_HEIGHT + 1'b1;

   typedef struct packed {
      logic                 mode;
      logic signed [CB-1:0] start_x;
      logic signed [CB-1:0] start_y;
      logic signed [CB-1:0] finish_x;
      logic signed [CB-1:0] finish_y;
      logic [COLOR_BITS-1:0] color;
   } line_word_type;

   typedef struct packed {
      logic [AB-1:0]         address;
      logic                  ok;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   class pixel_scoreboard;
      bit               active;
      bit               major_x;
      int               major_index;
      int               major_end;
      int               delta_minor;
      int               delta_major;
      int               intercept;
      logic [COLOR_BITS-1:0] held_color;
      int unsigned      width;
      int unsigned      height;
      pixel_type        pixel_q[$];
      int               failures;

      function new();
         active      = 1'b0;
         major_x     = 1'b0;
         major_index = 0;
         major_end   = 0;
         delta_minor = 0;
         delta_major = 0;
         intercept   = 0;
         held_color  = '0;
         width       = 32'(IMAGE_WIDTH_RESET);
         height      = 32'(IMAGE_HEIGHT_RESET);
         failures    = 0;
      endfunction

      function int pending();
         return pixel_q.size();
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx, logic [DIM_BITS-1:0] value);
         case (idx)
            REG_IMAGE_WIDTH:  width = 32'(value);
            REG_IMAGE_HEIGHT: height = 32'(value);
            default: ;
         endcase
      endfunction

      function int mag(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void note_request(line_word_type w);
         int     x1, y1, x2, y2, ma1, ma2, mi1, mi2, t;
         longint minor, px, py, addr, limit;
         pixel_type p;
         if (w.mode == MODE_START) begin
            x1 = int'(w.start_x);
            y1 = int'(w.start_y);
            x2 = int'(w.finish_x);
            y2 = int'(w.finish_y);
            // A tie in the two spans goes to the y axis.
            major_x = mag(x2 - x1) > mag(y2 - y1);
            if (major_x) begin
               ma1 = x1; ma2 = x2; mi1 = y1; mi2 = y2;
            end else begin
               ma1 = y1; ma2 = y2; mi1 = x1; mi2 = x2;
            end
            if (ma2 < ma1) begin
               t = ma1; ma1 = ma2; ma2 = t;
               t = mi1; mi1 = mi2; mi2 = t;
            end
            held_color  = w.color;
            major_index = ma1;
            major_end   = ma2;
            delta_major = ma2 - ma1;
            delta_minor = mi2 - mi1;
            if (delta_major == 0) begin
               active    = 1'b0;
               intercept = 0;
            end else begin
               active    = 1'b1;
               intercept = int'(longint'(mi1) - (longint'(ma1) * delta_minor) / delta_major);
            end
            return;
         end
         if (!active || major_index >= major_end || delta_major == 0) begin
            active = 1'b0;
            return;
         end
         minor     = (longint'(major_index) * delta_minor) / delta_major + intercept;
         px        = major_x ? longint'(major_index) : minor;
         py        = major_x ? minor : longint'(major_index);
         addr      = px + py * longint'(width);
         limit     = longint'(width) * longint'(height);
         p.address = addr[AB-1:0];
         p.ok      = (addr >= 0) && (addr < limit);
         p.color   = held_color;
         p.last    = (major_index + 1) >= major_end;
         pixel_q.push_back(p);
         major_index++;
         if (p.last) active = 1'b0;
      endfunction

      function void check_result(pixel_type got);
         pixel_type exp_pixel;
         if (pixel_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: pixel word with none expected: addr %h ok %0b color %h last %0b",
                        got.address, got.ok, got.color, got.last);
            return;
         end
         exp_pixel = pixel_q.pop_front();
         if (got.address !== exp_pixel.address || got.ok !== exp_pixel.ok ||
             got.color !== exp_pixel.color || got.last !== exp_pixel.last) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: pixel mismatch: expected addr %h ok %0b color %h last %0b,",
                        exp_pixel.address, exp_pixel.ok, exp_pixel.color, exp_pixel.last,
                        " got addr %h ok %0b color %h last %0b",
                        got.address, got.ok, got.color, got.last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lpg_req_if req_ch ();
   lpg_rsp_if rsp_ch ();
   lpg_csr_if csr_ch ();

   line_pixel_generator_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   pixel_scoreboard sb = new();
   int req_idle_pct = 38;
   int rsp_idle_pct = 49;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("line_pixel_generator_top test failed");
      $finish;
   end

   // Result side: takes accepted pixel words and stalls at random.
   always @(posedge clock) begin
      pixel_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.address = rsp_ch.pixel_address;
         got.ok      = rsp_ch.address_ok;
         got.color   = rsp_ch.pixel_color;
         got.last    = rsp_ch.last_pixel;
         sb.check_result(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic int clamp_coord(int v);
      if (v < -(1 << (CB - 1))) return -(1 << (CB - 1));
      if (v > (1 << (CB - 1)) - 1) return (1 << (CB - 1)) - 1;
      return v;
   endfunction

   // For a nonzero size, half the picks land inside the image so that in-range addresses show up.
   function automatic int pick_coord(int unsigned dim);
      if (dim != 0 && $urandom_range(1) == 1)
         return int'($urandom_range(dim - 1));
      return int'($urandom_range((1 << CB) - 1)) - (1 << (CB - 1));
   endfunction

   function automatic line_word_type start_word(int x1, int y1, int x2, int y2,
                                                logic [COLOR_BITS-1:0] color);
      line_word_type w;
      w.mode     = MODE_START;
      w.start_x  = x1[CB-1:0];
      w.start_y  = y1[CB-1:0];
      w.finish_x = x2[CB-1:0];
      w.finish_y = y2[CB-1:0];
      w.color    = color;
      return w;
   endfunction

   // Step words carry random endpoint and color bits that the block must ignore.
   function automatic line_word_type step_word();
      line_word_type w;
      w = start_word(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                     COLOR_BITS'($urandom_range((1 << COLOR_BITS) - 1)));
      w.mode = MODE_STEP;
      return w;
   endfunction

   task automatic send_word(input line_word_type w);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= w.mode;
      req_ch.start_x    <= w.start_x;
      req_ch.start_y    <= w.start_y;
      req_ch.finish_x   <= w.finish_x;
      req_ch.finish_y   <= w.finish_y;
      req_ch.line_color <= w.color;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(w);
   endtask

   task automatic send_steps(input int count);
      repeat (count) send_word(step_word());
   endtask

   // Waits until every pixel has come back and any start still in work is done.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_size(input int width, input int height, input bit poke_unused);
      logic [CSR_INDEX_BITS-1:0] idx [3];
      logic [DIM_BITS-1:0]       value [3];
      int                        first;
      idx[0]   = CSR_INDEX_BITS'($urandom_range((1 << CSR_INDEX_BITS) - 1, REG_UNUSED));
      value[0] = DIM_BITS'($urandom_range((1 << DIM_BITS) - 1));
      idx[1]   = REG_IMAGE_WIDTH;
      value[1] = width[DIM_BITS-1:0];
      idx[2]   = REG_IMAGE_HEIGHT;
      value[2] = height[DIM_BITS-1:0];
      first    = poke_unused ? 0 : 1;
      for (int i = first; i < 3; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[i];
         csr_ch.data  <= value[i];
         do @(posedge clock); while (!csr_ch.ready);
         sb.write_register(idx[i], value[i]);
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_directed();
      send_word(step_word());
      send_word(start_word(-4096, -4096, 4095, 4095, 24'hFFFFFF));
      send_steps(2);
      // Falling x-major line: the endpoints must be swapped on the x axis.
      send_word(start_word(10, 5, 3, 2, 24'h000000));
      send_steps(8);
      send_word(start_word(100, 100, 100, 100, 24'h5A5A5A));
      send_steps(1);
      send_word(start_word(4095, -4096, -4096, 4095, 24'hA5A5A5));
      send_steps(2);
      send_word(start_word(0, 0, 3, 5, 24'h123456));
      send_steps(6);
   endtask

   task automatic run_random(input int target);
      int counted, kind, span, x1, y1, x2, y2, dmaj, steps;
      counted = 0;
      while (counted < target) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_word(step_word());
         end else if (kind < 14) begin
            x1 = pick_coord(sb.width);
            y1 = pick_coord(sb.height);
            send_word(start_word(x1, y1, x1, y1,
                                 COLOR_BITS'($urandom_range((1 << COLOR_BITS) - 1))));
            counted++;
            send_steps($urandom_range(1));
         end else begin
            if (kind < 26) begin
               x1 = pick_coord(0);
               y1 = pick_coord(0);
               x2 = pick_coord(0);
               y2 = pick_coord(0);
            end else begin
               span = (kind < 40) ? 60 : 12;
               x1 = pick_coord(sb.width);
               y1 = pick_coord(sb.height);
               x2 = clamp_coord(x1 + int'($urandom_range(2 * span)) - span);
               y2 = clamp_coord(y1 + int'($urandom_range(2 * span)) - span);
            end
            dmaj = (x2 > x1) ? x2 - x1 : x1 - x2;
            if (((y2 > y1) ? y2 - y1 : y1 - y2) > dmaj)
               dmaj = (y2 > y1) ? y2 - y1 : y1 - y2;
            // Long lines are only started and then abandoned after a few pixels.
            if (dmaj > 64)
               steps = $urandom_range(4, 1);
            else if ($urandom_range(9) == 0)
               steps = $urandom_range(dmaj);
            else
               steps = dmaj + $urandom_range(2);
            send_word(start_word(x1, y1, x2, y2,
                                 COLOR_BITS'($urandom_range((1 << COLOR_BITS) - 1))));
            send_steps(steps);
            counted += 1 + ((steps < dmaj) ? steps : dmaj);
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.mode       <= MODE_START;
      req_ch.start_x    <= '0;
      req_ch.start_y    <= '0;
      req_ch.finish_x   <= '0;
      req_ch.finish_y   <= '0;
      req_ch.line_color <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= REG_IMAGE_WIDTH;
      csr_ch.data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      settle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 2) begin
            req_idle_pct = 38;
            rsp_idle_pct = 49;
         end else if (phase < 4) begin
            req_idle_pct = 49;
            rsp_idle_pct = 38;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (phase)
            0: program_size(2048, 2048, 1'b0);
            1: program_size(1, 1, 1'b0);
            2: program_size(0, 640, 1'b1);
            3: program_size(4095, 4095, 1'b0);
            4: program_size(640, 480, 1'b1);
            default: program_size($urandom_range(2048, 1), $urandom_range(2048, 1), 1'b0);
         endcase
         run_random(PHASE_ITEMS);
         settle();
      end

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("line_pixel_generator_top test passed");
      end else begin
         $display("line_pixel_generator_top test failed");
      end
      $finish;
   end

endmodule
